### rtl/core/hfa_pkg.sv
// Shared types, constants and interface structs for the hole-fit allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hfa_pkg;

    // Table geometry
    localparam int MAX_HOLES  = 16;
    localparam int SIZE_BITS  = 32;
    localparam int ADDR_W     = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CNT_W      = $clog2(MAX_HOLES + 1);
    // Compare width: wide enough for both a hole size and a request
    localparam int CMP_W      = (SIZE_BITS > 32) ? SIZE_BITS : 32;

    // Word field widths
    localparam int CMD_W       = 2;
    localparam int IDX_W       = 4;
    localparam int REQ_W       = 32;
    localparam int REM_W       = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Configuration port
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_COUNT = 1'd1;
    localparam logic [COUNT_W-1:0]   HOLE_COUNT_RST = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_PROBE = 2'd2
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Table write request
    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [SIZE_BITS-1:0] data;
    } tbl_wr_t;

    // Registered table read, tagged with the entry it came from
    typedef struct packed {
        logic                 valid;
        logic [ADDR_W-1:0]    idx;
        logic [SIZE_BITS-1:0] size;
    } tbl_rd_t;

    // Control into the fit unit
    typedef struct packed {
        logic             start;
        fit_mode_t        mode;
        logic [CMP_W-1:0] req;
    } fit_ctl_t;

    // Current pick of the fit unit
    typedef struct packed {
        logic                 found;
        logic [ADDR_W-1:0]    idx;
        logic [SIZE_BITS-1:0] size;
        logic [SIZE_BITS-1:0] rem;
    } fit_stat_t;

endpackage

### rtl/core/hfa_table.sv
// Hole-size table: one write port, one registered read port, per-entry valid bits.
// Depends on hfa_pkg.
`timescale 1ns / 1ps

module hfa_table (
    input  logic             aclk,
    input  logic             aresetn,
    input  hfa_pkg::tbl_wr_t wr,
    input  logic             rd_en,
    input  logic [hfa_pkg::ADDR_W-1:0] rd_addr,
    output hfa_pkg::tbl_rd_t rd
);
    import hfa_pkg::*;

    logic [SIZE_BITS-1:0] hole_mem_reg [MAX_HOLES];
    logic [MAX_HOLES-1:0] valid_reg;
    logic [SIZE_BITS-1:0] rd_data_reg;
    logic                 rd_hit_reg;
    logic                 rd_valid_reg;
    logic [ADDR_W-1:0]    rd_idx_reg;

    // Storage write
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            hole_mem_reg[wr.addr] <= wr.data;
        end
    end

    // Valid bits: an entry never loaded reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rd_data_reg <= hole_mem_reg[rd_addr];
        rd_hit_reg  <= valid_reg[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd.valid = rd_valid_reg;
    assign rd.idx   = rd_idx_reg;
    assign rd.size  = rd_hit_reg ? rd_data_reg : '0;

endmodule

### rtl/core/hfa_fit_unit.sv
// Shared fit unit: one fit compare and one rank compare per scanned entry,
// keeps the current pick and its size after subtraction. Depends on hfa_pkg.
`timescale 1ns / 1ps

module hfa_fit_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  hfa_pkg::fit_ctl_t ctl,
    input  hfa_pkg::tbl_rd_t  rd,
    output hfa_pkg::fit_stat_t stat
);
    import hfa_pkg::*;

    logic                 found_reg;
    logic [ADDR_W-1:0]    idx_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic                 fits;
    logic                 better;
    logic                 take;

    // Fit test and rank against the current pick
    always_comb begin
        fits = CMP_W'(rd.size) >= ctl.req;
        case (ctl.mode)
            FIT_BEST:  better = rd.size < size_reg;
            FIT_WORST: better = rd.size > size_reg;
            default:   better = 1'b0;
        endcase
        // strict compares keep the lowest index on a tie
        take = rd.valid && fits && (!found_reg || better);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.start) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            idx_reg  <= rd.idx;
            size_reg <= rd.size;
        end
    end

    assign stat.found = found_reg;
    assign stat.idx   = idx_reg;
    assign stat.size  = size_reg;
    assign stat.rem   = SIZE_BITS'(CMP_W'(size_reg) - ctl.req);

endmodule

### rtl/core/hole_fit_allocator_unit.sv
// Top level of the hole-fit allocator: sequencer, configuration registers,
// output register. Depends on hfa_pkg, hfa_table and hfa_fit_unit.
`timescale 1ns / 1ps

// A load word (or an unused command) goes from idle straight to the finish
// state; an allocate or probe word first passes through the scan state,
// which reads n table entries, where n is hole_count capped at the table
// depth. From the finish state the result is registered once the output
// register is free, and the sequencer returns to idle, where the next word is
// taken. The scan is paced by the single fit unit, which sees one table
// entry per cycle through the table's registered read port. One word is
// worked on at a time: s_tready is high only while the sequencer is idle, and
// a finished result waits in the output register while the next word is
// taken. The table reads as all zero after reset with no clearing pass.
// Configuration is to be written only while no word is in flight.

module hole_fit_allocator_unit (
    input  logic aclk,
    input  logic aresetn,

    // Configuration write port
    input  logic                           cfg_we,
    input  logic [hfa_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [hfa_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // Command words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hfa_pkg::IN_TDATA_W-1:0]  s_tdata,  // hole_index, request_size, pad
    input  logic [hfa_pkg::CMD_W-1:0]       s_tuser,  // cmd

    // Result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hfa_pkg::OUT_TDATA_W-1:0] m_tdata,  // chosen_hole, remaining_size, pad
    output logic [0:0]                      m_tuser   // granted
);
    import hfa_pkg::*;

    state_t               state_reg, state_next;
    fit_mode_t            fit_mode_reg;
    logic [COUNT_W-1:0]   hole_count_reg;
    logic [CNT_W-1:0]     active_n;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    cmd_t                 cmd_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [REQ_W-1:0]     req_reg;
    fit_mode_t            mode_reg;
    logic                 accept;
    logic                 out_free;
    logic                 rd_en;
    tbl_wr_t              tbl_wr;
    tbl_rd_t              tbl_rd;
    fit_ctl_t             fit_ctl;
    fit_stat_t            fit_stat;
    logic                 res_load;
    logic                 res_granted;
    logic [IDX_W-1:0]     res_chosen;
    logic [REM_W-1:0]     res_remain;
    logic                 m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg   <= FIT_FIRST;
            hole_count_reg <= HOLE_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_FIT_MODE:   fit_mode_reg   <= fit_mode_t'(cfg_wdata[MODE_W-1:0]);
                CFG_HOLE_COUNT: hole_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Active hole count, saturated at the table depth
    always_comb begin
        if (int'(hole_count_reg) > MAX_HOLES) begin
            active_n = CNT_W'(MAX_HOLES);
        end else begin
            active_n = CNT_W'(hole_count_reg);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Word capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= cmd_t'(s_tuser);
            idx_reg  <= s_tdata[IDX_W-1:0];
            req_reg  <= s_tdata[IDX_W +: REQ_W];
            // probe always ranks by first fit
            mode_reg <= (cmd_t'(s_tuser) == CMD_PROBE) ? FIT_FIRST : fit_mode_reg;
        end
    end

    // Table and fit unit
    hfa_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg[ADDR_W-1:0]),
        .rd      (tbl_rd)
    );

    assign fit_ctl.start = accept;
    assign fit_ctl.mode  = mode_reg;
    assign fit_ctl.req   = CMP_W'(req_reg);

    hfa_fit_unit u_fit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (fit_ctl),
        .rd      (tbl_rd),
        .stat    (fit_stat)
    );

    // Result of the word in hand, valid in the finish state
    always_comb begin
        res_load    = int'(idx_reg) < MAX_HOLES;
        res_granted = 1'b0;
        res_chosen  = '0;
        res_remain  = '0;
        tbl_wr.en   = 1'b0;
        tbl_wr.addr = fit_stat.idx;
        tbl_wr.data = fit_stat.rem;
        case (cmd_reg)
            CMD_LOAD: begin
                res_chosen  = idx_reg;
                tbl_wr.addr = ADDR_W'(idx_reg);
                tbl_wr.data = SIZE_BITS'(req_reg);
                if (res_load) begin
                    res_granted = 1'b1;
                    res_remain  = REM_W'(CMP_W'(SIZE_BITS'(req_reg)));
                    tbl_wr.en   = 1'b1;
                end
            end
            CMD_ALLOC: begin
                if (fit_stat.found) begin
                    res_granted = 1'b1;
                    res_chosen  = IDX_W'(fit_stat.idx);
                    res_remain  = REM_W'(CMP_W'(fit_stat.rem));
                    tbl_wr.en   = 1'b1;
                end
            end
            CMD_PROBE: begin
                if (fit_stat.found) begin
                    res_granted = 1'b1;
                    res_chosen  = IDX_W'(fit_stat.idx);
                    res_remain  = REM_W'(CMP_W'(fit_stat.size));
                end
            end
            default: ;
        endcase
        // commit only when the result can be registered
        if (state_reg != ST_FINISH || !out_free) begin
            tbl_wr.en = 1'b0;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        rd_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                ptr_next = '0;
                if (accept) begin
                    if (cmd_t'(s_tuser) == CMD_ALLOC || cmd_t'(s_tuser) == CMD_PROBE) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                // one entry read per cycle; the last read lands as we leave
                if (ptr_reg == active_n) begin
                    state_next = ST_FINISH;
                end else begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_FINISH && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_tdata_reg <= {(OUT_TDATA_W - REM_W - IDX_W)'(0), res_remain, res_chosen};
            m_tuser_reg <= res_granted;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Checks
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result word raised outside the finish state");

    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (ptr_reg <= active_n))
        else $error("scan pointer ran past the active hole count");

    a_pick_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && fit_stat.found && cmd_reg != CMD_LOAD)
        |-> (CNT_W'(fit_stat.idx) < active_n))
        else $error("picked hole lies outside the active holes");

    a_load_skips_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd_t'(s_tuser) == CMD_LOAD) |=> (state_reg == ST_FINISH))
        else $error("load word did not go straight to finish");

endmodule

### tb/tb_top.sv
// Self-checking bench for hole_fit_allocator_unit: first, best and worst fit over a
// table of hole sizes, with a built-in predictor and a result queue.
// Depends on hfa_pkg and the hole_fit_allocator_unit RTL only.
`timescale 1ns / 1ps

module tb_top;
    import hfa_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_SPARE    = 2'd3;   // unused command code
    localparam logic [MODE_W-1:0] FIT_SPARE    = 2'd3;   // unused mode, behaves as first fit
    localparam int                RANDOM_WORDS = 1700;
    localparam int                HOLD_CYCLES  = 300;
    localparam int                IDLE_SETTLE  = 24;     // longer than one word with all 16 holes scanned
    localparam int unsigned       CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  hole;
        logic [REM_W-1:0]  remain;
    } alloc_result_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // hole_index, request_size, pad
    logic [CMD_W-1:0]       s_tuser   = '0;  // cmd
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // chosen_hole, remaining_size, pad
    logic [0:0]             m_tuser;         // granted

    // Predictor state: hole table and the two settings
    logic [SIZE_BITS-1:0] hole_tbl [MAX_HOLES];
    logic [MODE_W-1:0]    fit_mode_q   = FIT_FIRST;
    logic [COUNT_W-1:0]   hole_count_q = HOLE_COUNT_RST;

    alloc_result_t pending_results[$];
    int            mismatch_count = 0;
    int unsigned   cycle_count    = 0;
    bit            steady_flow    = 1'b0;  // no gaps on either side
    bit            hold_results   = 1'b0;  // asks the sink for one long hold-off

    hole_fit_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < MAX_HOLES; i++) hole_tbl[i] = '0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL hole_fit_allocator_unit");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor: one result per command word, table updated in place
    // ---------------------------------------------------------------
    function automatic alloc_result_t predict_outcome(logic [CMD_W-1:0] op,
                                                      logic [IDX_W-1:0] idx,
                                                      logic [REQ_W-1:0] req);
        alloc_result_t     res;
        int                pick;
        int                span;
        logic [MODE_W-1:0] policy;
        res  = '0;
        pick = -1;
        span = (hole_count_q > MAX_HOLES) ? MAX_HOLES : int'(hole_count_q);
        // probe always looks for the first fitting hole
        policy = (op == CMD_ALLOC) ? fit_mode_q : FIT_FIRST;
        if (op == CMD_LOAD) begin
            hole_tbl[idx] = req;
            res.granted   = 1'b1;
            res.hole      = idx;
            res.remain    = req;
        end else if (op == CMD_ALLOC || op == CMD_PROBE) begin
            for (int i = 0; i < span; i++) begin
                if (hole_tbl[i] >= req) begin
                    if (pick < 0)
                        pick = i;
                    else if (policy == FIT_BEST && hole_tbl[i] < hole_tbl[pick])
                        pick = i;
                    else if (policy == FIT_WORST && hole_tbl[i] > hole_tbl[pick])
                        pick = i;
                end
            end
            if (pick >= 0) begin
                if (op == CMD_ALLOC) hole_tbl[pick] = hole_tbl[pick] - req;
                res.granted = 1'b1;
                res.hole    = pick[IDX_W-1:0];
                res.remain  = hole_tbl[pick];
            end
        end
        return res;
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow) return 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Hole size: mostly small, some wide, some extremes, some copies (ties)
    function automatic logic [SIZE_BITS-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(0, 255);
        if (r < 65) return $urandom_range(0, 65535);
        if (r < 80) return hole_tbl[$urandom_range(0, MAX_HOLES - 1)];
        if (r < 92) return $urandom();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return SIZE_BITS'(1);
            2:       return {SIZE_BITS{1'b1}} - 1;
            default: return {SIZE_BITS{1'b1}};
        endcase
    endfunction

    // Request aimed at a given hole, so that most of them find a fit
    function automatic logic [REQ_W-1:0] pick_request(logic [IDX_W-1:0] k);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, hole_tbl[k]);
        if (r < 72) return hole_tbl[k];
        if (r < 82) return hole_tbl[k] + 1;
        return pick_size();
    endfunction

    task automatic report_mismatch(string what, logic [REM_W-1:0] got, logic [REM_W-1:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // Sender: holds valid from one word to the next when there is no gap
    // ---------------------------------------------------------------
    task automatic send_word(logic [CMD_W-1:0] op, logic [IDX_W-1:0] idx,
                             logic [REQ_W-1:0] req);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W - IDX_W - REQ_W){1'b0}}, req, idx};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_outcome(op, idx, req));
    endtask

    // Drop valid, wait for every pending result, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    // Leaves cfg_we high; apply_setting lowers it once both writes are done
    task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        if (addr == CFG_FIT_MODE) fit_mode_q = value[MODE_W-1:0];
        else hole_count_q = value[COUNT_W-1:0];
    endtask

    task automatic apply_setting(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count);
        wait_idle();
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_HOLE_COUNT, CFG_DATA_W'(count));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_word(output bit counted);
        int               r;
        logic [IDX_W-1:0] k;
        r = $urandom_range(0, 99);
        k = IDX_W'($urandom_range(0, MAX_HOLES - 1));
        counted = 1'b1;
        if (r < 28)
            send_word(CMD_LOAD, k, pick_size());
        else if (r < 78)
            send_word(CMD_ALLOC, IDX_W'($urandom_range(0, 15)), pick_request(k));
        else if (r < 95)
            send_word(CMD_PROBE, IDX_W'($urandom_range(0, 15)), pick_request(k));
        else begin
            send_word(CMD_SPARE, IDX_W'($urandom_range(0, 15)), $urandom());
            counted = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Table is all zero straight after reset
    task automatic test_reset_state();
        send_word(CMD_PROBE, 4'd0, '0);
        send_word(CMD_ALLOC, 4'd9, 32'd1);
        send_word(CMD_SPARE, 4'hF, 32'hFFFF_FFFF);
    endtask

    // Size extremes, zero request on an empty hole, exact fit
    task automatic test_load_extremes();
        send_word(CMD_LOAD, 4'hF, 32'hFFFF_FFFF);
        send_word(CMD_LOAD, 4'h0, 32'h0);
        send_word(CMD_LOAD, 4'hA, 32'h5A5A_A5A5);
        send_word(CMD_ALLOC, 4'h3, 32'hFFFF_FFFF);
        send_word(CMD_PROBE, 4'hC, 32'h0);
        send_word(CMD_ALLOC, 4'h6, 32'h0);
    endtask

    // Same request under each policy, with tied sizes in the table
    task automatic test_fit_policies();
        apply_setting(FIT_FIRST, 5'd5);
        send_word(CMD_LOAD, 4'd0, 32'd7);
        send_word(CMD_LOAD, 4'd1, 32'd100);
        send_word(CMD_LOAD, 4'd2, 32'd50);
        send_word(CMD_LOAD, 4'd3, 32'd100);
        send_word(CMD_LOAD, 4'd4, 32'd50);
        send_word(CMD_ALLOC, 4'd0, 32'd40);
        apply_setting(FIT_BEST, 5'd5);
        send_word(CMD_ALLOC, 4'd0, 32'd40);
        apply_setting(FIT_WORST, 5'd5);
        send_word(CMD_ALLOC, 4'd0, 32'd40);
        send_word(CMD_PROBE, 4'd0, 32'd55);
        apply_setting(FIT_SPARE, 5'd5);
        send_word(CMD_ALLOC, 4'd0, 32'd40);
    endtask

    // No active hole, a count beyond the table depth, and one just below it
    task automatic test_hole_count();
        apply_setting(FIT_FIRST, 5'd0);
        send_word(CMD_PROBE, 4'd0, 32'd0);
        send_word(CMD_ALLOC, 4'd0, 32'd0);
        apply_setting(FIT_WORST, 5'd31);
        send_word(CMD_LOAD, 4'hF, 32'hFFFF_FFFF);
        send_word(CMD_PROBE, 4'd0, 32'hFFFF_FFFF);
        apply_setting(FIT_FIRST, 5'd15);
        send_word(CMD_PROBE, 4'd0, 32'hFFFF_FFFF);
    endtask

    // Sink holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        apply_setting(FIT_BEST, 5'd16);
        steady_flow  = 1'b1;
        hold_results = 1'b1;
        repeat (24) send_word(CMD_ALLOC, IDX_W'($urandom_range(0, 15)),
                              REQ_W'($urandom_range(0, 64)));
        wait_idle();
        steady_flow = 1'b0;
    endtask

    // Phases of random traffic, each under a fresh setting
    task automatic test_random_traffic();
        int               sent;
        bit               counted;
        logic [COUNT_W-1:0] count;
        int               r;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            r = $urandom_range(0, 9);
            if (r == 0) count = 5'd0;
            else if (r == 1) count = COUNT_W'($urandom_range(MAX_HOLES + 1, 31));
            else if (r == 2) count = 5'd1;
            else if (r < 6) count = COUNT_W'($urandom_range(2, MAX_HOLES - 1));
            else count = 5'd16;
            apply_setting(MODE_W'($urandom_range(0, 3)), count);
            steady_flow = ($urandom_range(0, 4) == 0);
            // refill the whole table now and then
            if ($urandom_range(0, 2) == 0) begin
                for (int i = 0; i < MAX_HOLES; i++)
                    send_word(CMD_LOAD, IDX_W'(i), pick_size());
                sent += MAX_HOLES;
            end
            repeat ($urandom_range(40, 120)) begin
                send_random_word(counted);
                if (counted) sent++;
            end
        end
        steady_flow = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result sink: random stalls, steady stretches, a long hold-off
    // ---------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                hold_results = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (steady_flow) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = rand_gap();
                m_tready  <= (stall_left == 0);
            end
        end
    end

    // Result checker: oldest expectation against each accepted word
    initial begin : result_check
        alloc_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with none pending", m_tdata[IDX_W +: REM_W], '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser[0] !== want.granted)
                        report_mismatch("granted", REM_W'(m_tuser[0]), REM_W'(want.granted));
                    if (m_tdata[IDX_W-1:0] !== want.hole)
                        report_mismatch("chosen_hole", REM_W'(m_tdata[IDX_W-1:0]),
                                        REM_W'(want.hole));
                    if (m_tdata[IDX_W +: REM_W] !== want.remain)
                        report_mismatch("remaining_size", m_tdata[IDX_W +: REM_W], want.remain);
                end
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_load_extremes();
        test_fit_policies();
        test_hole_count();
        test_backpressure();
        test_random_traffic();
        test_backpressure();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("PASS hole_fit_allocator_unit");
        end else begin
            $display("FAIL hole_fit_allocator_unit");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/hfa_pkg.sv
rtl/core/hfa_table.sv
rtl/core/hfa_fit_unit.sv
rtl/core/hole_fit_allocator_unit.sv
tb/tb_top.sv
